@@ sv/gld_pkg.sv @@
package gld_pkg;

  // Input item layout in s_axis_tdata, lowest bit first
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CoordW   = 8;
  localparam int unsigned GreyW    = 8;
  localparam int unsigned ModeLsb  = 0;
  localparam int unsigned RowLsb   = ModeLsb + ModeW;
  localparam int unsigned ColLsb   = RowLsb + CoordW;
  localparam int unsigned GreyLsb  = ColLsb + CoordW;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned KindW    = 1;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CfgSizeW = 9;

  localparam logic [CfgIdxW-1:0] CFG_DARK_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH_IN_USE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT_IN_USE  = 2'd2;

  localparam logic [GreyW-1:0]    THRESHOLD_RESET = 8'd230;
  localparam logic [CfgSizeW-1:0] SIZE_RESET      = 9'd256;

  localparam logic [ModeW-1:0] MODE_WRITE = 2'd0;
  localparam logic [ModeW-1:0] MODE_CLEAN = 2'd1;
  localparam logic [ModeW-1:0] MODE_READ  = 2'd2;

  localparam logic [KindW-1:0] KIND_READ = 1'b0;
  localparam logic [KindW-1:0] KIND_DONE = 1'b1;

  localparam logic [OutDataW-1:0] PIXEL_DARK  = 8'd0;
  localparam logic [OutDataW-1:0] PIXEL_LIGHT = 8'd255;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic host_wr;
    logic host_rd;
    logic walk_start;
    logic scan_rd;
    logic clear_wr;
    logic line_rewind;
    logic line_next;
    logic load_read;
    logic load_done;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             in_valid;
    logic [ModeW-1:0] in_mode;
    logic             frame_empty;
    logic             k_last;
    logic             is_line;
    logic             line_last;
    logic             pass_row;
    logic             out_free;
  } sts_t;

endpackage

@@ sv/grid_line_removal.sv @@
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: mode, row, column, pixel_in
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: pixel_out; tuser: result_kind
// cfg       in   cfg_we_i (no wait)             cfg_idx_i, cfg_wdata_i
//
// Pixel write: writes stream back to back while no read is pending and no removal runs.
// Pixel read: data goes to the RAM output register, then to the result register once
//   the result slot frees; the next item waits until that load.
// Removal: each pass scans every line (SCAN, TAIL, DECIDE), clearing removed lines;
//   input stalls until the finish result is loaded.
// rst_ni clears control and loads register defaults; the pixel RAM is not cleared.
module grid_line_removal #(
  parameter int unsigned MaxWidth   = 256,
  parameter int unsigned MaxHeight  = 256,
  parameter int unsigned RunDivisor = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] mode, [9:2] row, [17:10] column, [25:18] pixel_in, [31:26] zero
  input  logic [gld_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] pixel_out
  output logic [gld_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] result_kind
  output logic [gld_pkg::KindW-1:0]     m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [gld_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gld_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  gld_pkg::cmd_t cmd;
  gld_pkg::sts_t sts;

  gld_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  gld_dpath #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight),
    .RunDivisor(RunDivisor)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

@@ sv/gld_ram.sv @@
module gld_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/gld_ctrl.sv @@
module gld_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gld_pkg::sts_t sts_i,
  output gld_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_TAIL   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_CLEAR  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   rd_pend_q, rd_pend_d;

  always_comb begin
    state_d   = state_q;
    rd_pend_d = rd_pend_q;
    cmd_o     = '0;

    // a read waits in the RAM output register until the result slot frees
    if (rd_pend_q && sts_i.out_free) begin
      cmd_o.load_read = 1'b1;
      rd_pend_d       = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = !rd_pend_q;
        if (sts_i.in_valid && !rd_pend_q) begin
          priority if (sts_i.in_mode == gld_pkg::MODE_WRITE) begin
            cmd_o.host_wr = 1'b1;
          end else if (sts_i.in_mode == gld_pkg::MODE_READ) begin
            cmd_o.host_rd = 1'b1;
            rd_pend_d     = 1'b1;
          end else if (sts_i.in_mode == gld_pkg::MODE_CLEAN) begin
            cmd_o.walk_start = 1'b1;
            state_d = sts_i.frame_empty ? ST_DONE : ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.k_last) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.is_line) begin
          cmd_o.line_rewind = 1'b1;
          state_d = ST_CLEAR;
        end else begin
          cmd_o.line_next = 1'b1;
          state_d = (sts_i.line_last && sts_i.pass_row) ? ST_DONE : ST_SCAN;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.k_last) begin
          cmd_o.line_next = 1'b1;
          state_d = (sts_i.line_last && sts_i.pass_row) ? ST_DONE : ST_SCAN;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_done = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  a_pend_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> state_q == ST_IDLE)
    else $error("read pending outside idle");

  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.walk_start && !sts_i.frame_empty |=> state_q == ST_SCAN)
    else $error("removal did not start scanning");

  a_done_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && sts_i.out_free |=> state_q == ST_IDLE && !rd_pend_q)
    else $error("finish result not delivered");

endmodule

@@ sv/gld_dpath.sv @@
module gld_dpath #(
  parameter int unsigned MaxWidth   = 256,
  parameter int unsigned MaxHeight  = 256,
  parameter int unsigned RunDivisor = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gld_pkg::cmd_t                 cmd_i,
  output gld_pkg::sts_t                 sts_o,
  input  logic                          s_axis_tvalid,
  input  logic [gld_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [gld_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [gld_pkg::KindW-1:0]     m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [gld_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gld_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned Depth  = MaxWidth * MaxHeight;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned MaxDim = (MaxWidth > MaxHeight) ? MaxWidth : MaxHeight;
  localparam int unsigned DimW   = $clog2(MaxDim + 1);
  localparam int unsigned SzW    = (DimW > gld_pkg::CfgSizeW) ? DimW : gld_pkg::CfgSizeW;
  // run length kept scaled by the divisor: run > n / D  <=>  run * D > n
  localparam int unsigned RxW    = $clog2(MaxDim * RunDivisor + 1);

  // configuration
  logic [gld_pkg::GreyW-1:0]    thresh_q;
  logic [gld_pkg::CfgSizeW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= gld_pkg::THRESHOLD_RESET;
      width_q  <= gld_pkg::SIZE_RESET;
      height_q <= gld_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gld_pkg::CFG_DARK_THRESHOLD: thresh_q <= cfg_wdata_i[gld_pkg::GreyW-1:0];
        gld_pkg::CFG_WIDTH_IN_USE:   width_q  <= cfg_wdata_i;
        gld_pkg::CFG_HEIGHT_IN_USE:  height_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // input item fields
  logic [gld_pkg::ModeW-1:0]  in_mode;
  logic [gld_pkg::CoordW-1:0] in_row, in_col;
  logic [gld_pkg::GreyW-1:0]  in_grey;
  logic                       host_inside;
  logic [AddrW-1:0]           host_addr;

  assign in_mode = s_axis_tdata[gld_pkg::ModeLsb +: gld_pkg::ModeW];
  assign in_row  = s_axis_tdata[gld_pkg::RowLsb +: gld_pkg::CoordW];
  assign in_col  = s_axis_tdata[gld_pkg::ColLsb +: gld_pkg::CoordW];
  assign in_grey = s_axis_tdata[gld_pkg::GreyLsb +: gld_pkg::GreyW];

  assign host_inside = (32'(in_row) < MaxHeight) && (32'(in_col) < MaxWidth);
  assign host_addr   = AddrW'(32'(in_row) * MaxWidth + 32'(in_col));

  // sizes saturated to the store
  logic [SzW-1:0] w_sat, h_sat;
  assign w_sat = (32'(width_q) > MaxWidth) ? SzW'(MaxWidth) : SzW'(width_q);
  assign h_sat = (32'(height_q) > MaxHeight) ? SzW'(MaxHeight) : SzW'(height_q);

  // removal walk
  logic           pass_q, pass_d;
  logic [SzW-1:0] w_q, w_d, h_q, h_d;
  logic [SzW-1:0] line_q, line_d, k_q, k_d;
  logic [SzW-1:0] dark_q, dark_d;
  logic [RxW-1:0] runx_q, runx_d, runx_inc;
  logic           over_q, over_d;
  logic           scan_vld_q;
  logic [SzW-1:0] n_cur, lines_cur, walk_row, walk_col;
  logic [AddrW-1:0] walk_addr;
  logic           ram_rdata;
  logic           ram_we, ram_re;

  assign n_cur     = pass_q ? w_q : h_q;
  assign lines_cur = pass_q ? h_q : w_q;
  assign walk_row  = pass_q ? line_q : k_q;
  assign walk_col  = pass_q ? k_q : line_q;
  assign walk_addr = AddrW'(32'(walk_row) * MaxWidth + 32'(walk_col));
  assign runx_inc  = runx_q + RxW'(RunDivisor);

  always_comb begin
    pass_d = pass_q;
    w_d    = w_q;
    h_d    = h_q;
    line_d = line_q;
    k_d    = k_q;
    dark_d = dark_q;
    runx_d = runx_q;
    over_d = over_q;

    if (scan_vld_q) begin
      if (ram_rdata) begin
        dark_d = dark_q + 1'b1;
        runx_d = runx_inc;
        if (runx_inc > RxW'(n_cur)) begin
          over_d = 1'b1;
        end
      end else begin
        runx_d = '0;
      end
    end

    if (cmd_i.scan_rd || cmd_i.clear_wr) begin
      k_d = k_q + 1'b1;
    end
    if (cmd_i.line_rewind) begin
      k_d = '0;
    end
    if (cmd_i.line_next) begin
      k_d    = '0;
      dark_d = '0;
      runx_d = '0;
      over_d = 1'b0;
      if (sts_o.line_last && !pass_q) begin
        pass_d = 1'b1;
        line_d = '0;
      end else begin
        line_d = line_q + 1'b1;
      end
    end
    if (cmd_i.walk_start) begin
      pass_d = 1'b0;
      w_d    = w_sat;
      h_d    = h_sat;
      line_d = '0;
      k_d    = '0;
      dark_d = '0;
      runx_d = '0;
      over_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q     <= 1'b0;
      line_q     <= '0;
      k_q        <= '0;
      dark_q     <= '0;
      runx_q     <= '0;
      over_q     <= 1'b0;
      scan_vld_q <= 1'b0;
    end else begin
      pass_q     <= pass_d;
      line_q     <= line_d;
      k_q        <= k_d;
      dark_q     <= dark_d;
      runx_q     <= runx_d;
      over_q     <= over_d;
      scan_vld_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    h_q <= h_d;
  end

  // pixel store, one bit per pixel, 1 = dark
  assign ram_we = (cmd_i.host_wr && host_inside) || cmd_i.clear_wr;
  assign ram_re = cmd_i.host_rd || cmd_i.scan_rd;

  gld_ram #(
    .Width(1),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_i.clear_wr ? walk_addr : host_addr),
    .wdata_i(cmd_i.clear_wr ? 1'b0 : (in_grey < thresh_q)),
    .re_i   (ram_re),
    .raddr_i(cmd_i.scan_rd ? walk_addr : host_addr),
    .rdata_o(ram_rdata)
  );

  // result register
  logic                          out_valid_q, out_valid_d;
  logic [gld_pkg::KindW-1:0]     out_kind_q;
  logic [gld_pkg::OutDataW-1:0]  out_pix_q;
  logic                          rd_inside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.host_rd) begin
      rd_inside_q <= host_inside;
    end
    if (cmd_i.load_read) begin
      out_kind_q <= gld_pkg::KIND_READ;
      out_pix_q  <= (rd_inside_q && ram_rdata) ? gld_pkg::PIXEL_DARK : gld_pkg::PIXEL_LIGHT;
    end else if (cmd_i.load_done) begin
      out_kind_q <= gld_pkg::KIND_DONE;
      out_pix_q  <= gld_pkg::PIXEL_DARK;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_read || cmd_i.load_done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_kind_q;

  // status
  assign sts_o.in_valid    = s_axis_tvalid;
  assign sts_o.in_mode     = in_mode;
  assign sts_o.frame_empty = (w_sat == '0) || (h_sat == '0);
  assign sts_o.k_last      = (k_q == n_cur - 1'b1);
  assign sts_o.is_line     = over_q || ({dark_q, 1'b0} > {1'b0, n_cur});
  assign sts_o.line_last   = (line_q == lines_cur - 1'b1);
  assign sts_o.pass_row    = pass_q;
  assign sts_o.out_free    = !out_valid_q || m_axis_tready;

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_vld_q |-> !ram_we)
    else $error("store written while a line is being scanned");

endmodule

@@ dv/grid_line_removal_checker.sv @@
`timescale 1ns / 1ps

// Watches the input stream, config port and result stream of grid_line_removal.
// Keeps a shadow of the binarized frame and registers, predicts each result and
// compares it field by field against the oldest outstanding expectation.
// Sampling is done on the falling edge: everything is driven at the rising
// edge, so a transaction seen here completes at the next rising edge.
module grid_line_removal_checker #(
  parameter int unsigned MaxWidth   = 256,
  parameter int unsigned MaxHeight  = 256,
  parameter int unsigned RunDivisor = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  // [1:0] mode, [9:2] row, [17:10] column, [25:18] pixel_in, [31:26] zero
  input  logic [gld_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  // [7:0] pixel_out
  input  logic [gld_pkg::OutDataW-1:0] m_axis_tdata_i,
  // [0] result_kind
  input  logic [gld_pkg::KindW-1:0]    m_axis_tuser_i,
  input  logic                         cfg_we_i,
  input  logic [gld_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gld_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  typedef struct packed {
    logic [gld_pkg::KindW-1:0]    kind;
    logic [gld_pkg::OutDataW-1:0] pixel;
  } result_t;

  bit                           dark_px [MaxHeight][MaxWidth];
  logic [gld_pkg::GreyW-1:0]    threshold;
  logic [gld_pkg::CfgSizeW-1:0] width_cfg;
  logic [gld_pkg::CfgSizeW-1:0] height_cfg;
  result_t                      due_results [$];

  // One line of n pixels: a long dark run or a dark majority makes it a grid line.
  function automatic bit is_grid_line(int unsigned fixed, int unsigned n, bit along_column);
    int unsigned limit;
    int unsigned run;
    int unsigned dark;
    bit          px;
    limit = n / RunDivisor;
    run   = 0;
    dark  = 0;
    for (int unsigned k = 0; k < n; k++) begin
      px = along_column ? dark_px[k][fixed] : dark_px[fixed][k];
      if (px) begin
        dark++;
        run++;
      end else begin
        run = 0;
      end
      if (run > limit) return 1'b1;
    end
    return (2 * dark > n);
  endfunction

  // Column pass first, then rows on what the column pass left.
  function automatic void strip_grid_lines();
    int unsigned w;
    int unsigned h;
    w = (width_cfg > MaxWidth) ? MaxWidth : width_cfg;
    h = (height_cfg > MaxHeight) ? MaxHeight : height_cfg;
    for (int unsigned a = 0; a < w; a++) begin
      if (is_grid_line(a, h, 1'b1)) begin
        for (int unsigned b = 0; b < h; b++) dark_px[b][a] = 1'b0;
      end
    end
    for (int unsigned a = 0; a < h; a++) begin
      if (is_grid_line(a, w, 1'b0)) begin
        for (int unsigned b = 0; b < w; b++) dark_px[a][b] = 1'b0;
      end
    end
  endfunction

  always @(negedge clk_i) begin : watch
    result_t                    got;
    result_t                    want;
    logic [gld_pkg::ModeW-1:0]  mode;
    logic [gld_pkg::CoordW-1:0] row;
    logic [gld_pkg::CoordW-1:0] col;
    logic [gld_pkg::GreyW-1:0]  grey;
    if (!rst_ni) begin
      threshold    = gld_pkg::THRESHOLD_RESET;
      width_cfg    = gld_pkg::SIZE_RESET;
      height_cfg   = gld_pkg::SIZE_RESET;
      fail_count_o = 0;
      pending_o    = 0;
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gld_pkg::CFG_DARK_THRESHOLD:
            threshold  = cfg_wdata_i[gld_pkg::GreyW-1:0];
          gld_pkg::CFG_WIDTH_IN_USE:
            width_cfg  = cfg_wdata_i[gld_pkg::CfgSizeW-1:0];
          gld_pkg::CFG_HEIGHT_IN_USE:
            height_cfg = cfg_wdata_i[gld_pkg::CfgSizeW-1:0];
          default: ;
        endcase
      end

      // results first: a result never belongs to the item taken in the same cycle
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{kind: m_axis_tuser_i, pixel: m_axis_tdata_i};
        if (due_results.size() == 0) begin
          $error("unexpected result: result_kind %0d pixel_out %0d", got.kind, got.pixel);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, got.kind);
            fail_count_o++;
          end
          if (got.pixel !== want.pixel) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel, got.pixel);
            fail_count_o++;
          end
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        mode = s_axis_tdata_i[gld_pkg::ModeLsb +: gld_pkg::ModeW];
        row  = s_axis_tdata_i[gld_pkg::RowLsb +: gld_pkg::CoordW];
        col  = s_axis_tdata_i[gld_pkg::ColLsb +: gld_pkg::CoordW];
        grey = s_axis_tdata_i[gld_pkg::GreyLsb +: gld_pkg::GreyW];
        case (mode)
          gld_pkg::MODE_WRITE: begin
            if (row < MaxHeight && col < MaxWidth) dark_px[row][col] = (grey < threshold);
          end
          gld_pkg::MODE_CLEAN: begin
            strip_grid_lines();
            due_results.push_back('{kind: gld_pkg::KIND_DONE, pixel: '0});
          end
          gld_pkg::MODE_READ: begin
            if (row < MaxHeight && col < MaxWidth && dark_px[row][col])
              due_results.push_back('{kind: gld_pkg::KIND_READ, pixel: gld_pkg::PIXEL_DARK});
            else
              due_results.push_back('{kind: gld_pkg::KIND_READ, pixel: gld_pkg::PIXEL_LIGHT});
          end
          default: ;
        endcase
      end

      pending_o = due_results.size();
    end
  end

endmodule

@@ dv/grid_line_removal_test.sv @@
`timescale 1ns / 1ps

module grid_line_removal_test;

  localparam int unsigned ItemTarget   = 1700;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 8;

  typedef logic [gld_pkg::ModeW-1:0]    mode_t;
  typedef logic [gld_pkg::CoordW-1:0]   coord_t;
  typedef logic [gld_pkg::GreyW-1:0]    grey_t;
  typedef logic [gld_pkg::CfgDataW-1:0] cfg_word_t;

  // mode 3 has no function; the block must drop it
  localparam mode_t MODE_UNUSED = 2'd3;

  logic                         clk;
  logic                         rst_n;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [gld_pkg::InDataW-1:0]  s_tdata;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [gld_pkg::OutDataW-1:0] m_tdata;
  logic [gld_pkg::KindW-1:0]    m_tuser;
  logic                         cfg_we;
  logic [gld_pkg::CfgIdxW-1:0]  cfg_idx;
  cfg_word_t                    cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 68;
  int unsigned n_writes = 0;
  int unsigned n_reads = 0;
  int unsigned n_cleans = 0;
  int unsigned n_ignored = 0;
  int unsigned n_settings = 0;

  grey_t       cur_thr = gld_pkg::THRESHOLD_RESET;
  bit          written [256][256];
  logic [15:0] written_list [$];

  grid_line_removal dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  grid_line_removal_checker pixel_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("grid_line_removal_test NOT OK");
      $finish;
    end
  end

  function automatic grey_t grey_for(bit dark);
    if (dark && cur_thr != 0) return grey_t'($urandom_range(cur_thr - 1, 0));
    if (!dark) return grey_t'($urandom_range(255, cur_thr));
    return grey_t'($urandom_range(255, 0));
  endfunction

  // One input transaction, with a random gap in front of it.
  task automatic send(input mode_t mode, input coord_t row, input coord_t col,
                      input grey_t grey);
    logic [gld_pkg::InDataW-1:0] word;
    word = '0;
    word[gld_pkg::ModeLsb +: gld_pkg::ModeW]  = mode;
    word[gld_pkg::RowLsb +: gld_pkg::CoordW]  = row;
    word[gld_pkg::ColLsb +: gld_pkg::CoordW]  = col;
    word[gld_pkg::GreyLsb +: gld_pkg::GreyW]  = grey;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    case (mode)
      gld_pkg::MODE_WRITE: begin
        n_writes++;
        if (!written[row][col]) begin
          written[row][col] = 1'b1;
          written_list.push_back({row, col});
        end
      end
      gld_pkg::MODE_CLEAN: n_cleans++;
      gld_pkg::MODE_READ:  n_reads++;
      default:             n_ignored++;
    endcase
  endtask

  task automatic read_known_pixel();
    logic [15:0] addr;
    addr = written_list[$urandom_range(written_list.size() - 1)];
    send(gld_pkg::MODE_READ, addr[15:8], addr[7:0], grey_t'($urandom_range(255)));
  endtask

  // Drain all results, then let a trailing pixel write retire.
  task automatic go_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic configure(input cfg_word_t thr, input cfg_word_t w, input cfg_word_t h);
    cfg_we    <= 1'b1;
    cfg_idx   <= gld_pkg::CFG_DARK_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_idx   <= gld_pkg::CFG_WIDTH_IN_USE;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= gld_pkg::CFG_HEIGHT_IN_USE;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_thr    = thr[gld_pkg::GreyW-1:0];
    n_settings++;
  endtask

  initial begin
    int unsigned w_cfg;
    int unsigned h_cfg;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned noise_pct;
    int unsigned pick;
    int unsigned total;
    bit          col_line [256];
    bit          row_line [256];

    rst_n     <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= gld_pkg::CFG_DARK_THRESHOLD;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: corners and threshold boundary, unused mode, a tiny frame
    configure(cfg_word_t'(gld_pkg::THRESHOLD_RESET), 9'd3, 9'd3);
    send(gld_pkg::MODE_WRITE, 8'd0, 8'd0, 8'd0);
    send(gld_pkg::MODE_WRITE, 8'd255, 8'd255, 8'd255);
    send(gld_pkg::MODE_WRITE, 8'd0, 8'd255, gld_pkg::THRESHOLD_RESET - 8'd1);
    send(gld_pkg::MODE_WRITE, 8'd255, 8'd0, gld_pkg::THRESHOLD_RESET);
    send(gld_pkg::MODE_READ, 8'd0, 8'd0, 8'd0);
    send(gld_pkg::MODE_READ, 8'd255, 8'd255, 8'd255);
    send(gld_pkg::MODE_READ, 8'd0, 8'd255, 8'd0);
    send(gld_pkg::MODE_READ, 8'd255, 8'd0, 8'd255);
    send(MODE_UNUSED, 8'd255, 8'd255, 8'd255);
    // below the run divisor any dark pixel kills the line
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++)
        send(gld_pkg::MODE_WRITE, coord_t'(r), coord_t'(c), (c == 1) ? 8'd10 : 8'd240);
    end
    send(gld_pkg::MODE_CLEAN, 8'd0, 8'd0, 8'd0);
    send(gld_pkg::MODE_READ, 8'd0, 8'd1, 8'd0);
    send(gld_pkg::MODE_READ, 8'd1, 8'd0, 8'd0);
    send(gld_pkg::MODE_READ, 8'd2, 8'd2, 8'd0);
    go_idle();
    // empty frame: removal must still report done
    configure(cfg_word_t'(gld_pkg::THRESHOLD_RESET), 9'd0, 9'd3);
    send(gld_pkg::MODE_CLEAN, 8'd255, 8'd255, 8'd255);
    send(gld_pkg::MODE_READ, 8'd0, 8'd0, 8'd0);
    go_idle();

    total = n_writes + n_reads + n_cleans;
    while (total < ItemTarget) begin
      if (total < ItemTarget / 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 68;
      end else if (total < 2 * ItemTarget / 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      pick = $urandom_range(39);
      case (pick)
        0: begin w_cfg = 256; h_cfg = 1; end
        1: begin w_cfg = 1; h_cfg = 256; end
        2: begin w_cfg = $urandom_range(511, 257); h_cfg = 1; end
        3: begin w_cfg = 1; h_cfg = $urandom_range(511, 257); end
        4: begin w_cfg = 0; h_cfg = $urandom_range(16, 1); end
        5: begin w_cfg = $urandom_range(16, 1); h_cfg = 0; end
        default: begin w_cfg = $urandom_range(16, 1); h_cfg = $urandom_range(16, 1); end
      endcase
      pick = $urandom_range(5);
      configure((pick == 0) ? 9'd0 : (pick == 1) ? 9'd255 : cfg_word_t'($urandom_range(255)),
                cfg_word_t'(w_cfg), cfg_word_t'(h_cfg));
      w_eff = (w_cfg > 256) ? 256 : w_cfg;
      h_eff = (h_cfg > 256) ? 256 : h_cfg;

      // grid pattern: some full dark columns and rows over random speckle
      noise_pct = $urandom_range(60);
      for (int i = 0; i < 256; i++) begin
        col_line[i] = ($urandom_range(99) < 20);
        row_line[i] = ($urandom_range(99) < 20);
      end
      for (int unsigned r = 0; r < h_eff; r++) begin
        for (int unsigned c = 0; c < w_eff; c++) begin
          pick = $urandom_range(99);
          if (pick < 8) read_known_pixel();
          else if (pick < 11)
            send(gld_pkg::MODE_WRITE, coord_t'($urandom_range(255)),
                 coord_t'($urandom_range(255)), grey_t'($urandom_range(255)));
          else if (pick < 13)
            send(MODE_UNUSED, coord_t'($urandom_range(255)),
                 coord_t'($urandom_range(255)), grey_t'($urandom_range(255)));
          send(gld_pkg::MODE_WRITE, coord_t'(r), coord_t'(c),
               grey_for(col_line[c] || row_line[r] || ($urandom_range(99) < noise_pct)));
        end
      end
      if (w_eff == 0 || h_eff == 0) begin
        repeat (3)
          send(gld_pkg::MODE_WRITE, coord_t'($urandom_range(255)),
               coord_t'($urandom_range(255)), grey_t'($urandom_range(255)));
      end

      send(gld_pkg::MODE_CLEAN, coord_t'($urandom_range(255)),
           coord_t'($urandom_range(255)), grey_t'($urandom_range(255)));
      if ($urandom_range(4) == 0)
        send(gld_pkg::MODE_CLEAN, coord_t'($urandom_range(255)),
             coord_t'($urandom_range(255)), grey_t'($urandom_range(255)));

      repeat ($urandom_range(16, 4)) begin
        if (w_eff != 0 && h_eff != 0 && $urandom_range(3) != 0)
          send(gld_pkg::MODE_READ, coord_t'($urandom_range(h_eff - 1)),
               coord_t'($urandom_range(w_eff - 1)), grey_t'($urandom_range(255)));
        else
          read_known_pixel();
      end
      go_idle();
      total = n_writes + n_reads + n_cleans;
    end

    repeat (20) @(posedge clk);
    $display("covered %0d pixel writes, %0d reads and %0d removal passes over %0d frame settings",
             n_writes, n_reads, n_cleans, n_settings);
    $display("%0d unused-mode transactions sent, none may answer", n_ignored);
    if (fail_count == 0) begin
      $display("grid_line_removal_test OK");
    end else begin
      $display("grid_line_removal_test NOT OK");
    end
    $finish;
  end

endmodule
